// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the concurrent checks of page_run_allocator.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define PRA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("page allocator check failed");

// Next-cycle implication.
`define PRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("page allocator check failed");

`endif

// ===== rtl/pra_pkg.sv =====
// ---------------------------------------------------------------------------
// pra_pkg
// Types and constants of the page run allocator.
// ---------------------------------------------------------------------------
package pra_pkg;

    localparam int NUM_PAGES  = 1024;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_AW    = $clog2(NUM_PAGES);
    localparam int CNT_W      = PAGE_AW + 1;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int BYTES_W    = 23;
    localparam int PAGES_W    = BYTES_W + 1 - PAGE_SHIFT;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic MODE_NEXT_FIT = 1'b0;
    localparam logic MODE_BEST_FIT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_RUN = 2'd1,
        ST_ZERO   = 2'd2
    } t_status;

    typedef struct packed {
        logic               action;
        logic [BYTES_W-1:0] request_bytes;
        logic [PAGE_AW-1:0] free_page_index;
    } t_in_req;

    typedef struct packed {
        t_status            status;
        logic [PAGE_AW-1:0] page_index;
        logic [CNT_W-1:0]   page_count;
    } t_out_rsp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FREE_LD,
        S_FREE_CLR,
        S_SCAN,
        S_MARK,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    clear;
        logic    capture;
        logic    scan_init;
        logic    scan_restart;
        logic    scan;
        logic    len_load;
        logic    mark;
        logic    free_clr;
        logic    commit;
        logic    set_status;
        t_status status;
        logic    load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic is_free;
        logic size_zero;
        logic size_big;
        logic mode_best;
        logic found;
        logic scan_done;
        logic last_pass;
        logic mark_last;
        logic free_done;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/pra_ram.sv =====
// ---------------------------------------------------------------------------
// pra_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pra_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pra_dp.sv =====
// ---------------------------------------------------------------------------
// pra_dp
// Datapath: page bitmap and run length RAMs, scan counters, best-run
// tracking, next-fit pointer, mode register and output register.
// ---------------------------------------------------------------------------
module pra_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_data,
    input  pra_pkg::t_in_req  i_in_data,
    input  pra_pkg::t_cmd     i_cmd,
    output pra_pkg::t_stat    o_stat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pra_pkg::t_out_rsp o_out_data
);

    localparam int AW = pra_pkg::PAGE_AW;
    localparam int CW = pra_pkg::CNT_W;
    localparam logic [CW-1:0] NPAGES = CW'(pra_pkg::NUM_PAGES);

    logic                  r_mode, n_mode;
    pra_pkg::t_in_req      r_req, n_req;
    logic [CW-1:0]         r_want, n_want;
    logic [CW-1:0]         r_nfp, n_nfp;
    logic [CW-1:0]         r_addr, n_addr;
    logic                  r_rd_vld, n_rd_vld;
    logic [AW-1:0]         r_rd_addr, n_rd_addr;
    logic [CW-1:0]         r_run, n_run;
    logic [AW-1:0]         r_run_start, n_run_start;
    logic                  r_found, n_found;
    logic [CW-1:0]         r_best_len, n_best_len;
    logic [AW-1:0]         r_best_start, n_best_start;
    logic                  r_pass, n_pass;
    logic [CW-1:0]         r_wcnt, n_wcnt;
    pra_pkg::t_status      r_status, n_status;
    logic                  r_out_vld, n_out_vld;
    pra_pkg::t_out_rsp     r_out, n_out;

    logic [pra_pkg::BYTES_W:0]   bytes_up;
    logic [pra_pkg::PAGES_W-1:0] pages;
    logic                        used;
    logic [CW-1:0]               run_inc;
    logic [AW-1:0]               start_inc;
    logic                        last_page;
    logic                        run_close;
    logic [CW-1:0]               close_len;
    logic [AW-1:0]               close_start;
    logic [CW:0]                 free_end;
    logic                        scan_done;

    logic          bm_we;
    logic [AW-1:0] bm_waddr;
    logic          bm_wdata;
    logic          bm_rdata;
    logic          len_we;
    logic [AW-1:0] len_waddr;
    logic [CW-1:0] len_wdata;
    logic [CW-1:0] len_rdata;

    // Round the byte count up to whole pages.
    assign bytes_up = {1'b0, r_req.request_bytes}
                    + (pra_pkg::BYTES_W + 1)'(pra_pkg::PAGE_BYTES - 1);
    assign pages    = bytes_up[pra_pkg::BYTES_W:pra_pkg::PAGE_SHIFT];

    assign used        = bm_rdata;
    assign run_inc     = r_run + CW'(1);
    assign start_inc   = (r_run == '0) ? r_rd_addr : r_run_start;
    assign last_page   = (r_rd_addr == AW'(pra_pkg::NUM_PAGES - 1));
    assign run_close   = used || last_page;
    assign close_len   = used ? r_run : run_inc;
    assign close_start = used ? r_run_start : start_inc;
    assign free_end    = (CW + 1)'(r_req.free_page_index) + (CW + 1)'(r_wcnt);
    assign scan_done   = (r_addr == NPAGES) && !r_rd_vld;

    always_comb begin
        o_stat            = '0;
        o_stat.clear_last = (r_addr == NPAGES - CW'(1));
        o_stat.is_free    = (r_req.action == pra_pkg::ACT_FREE);
        o_stat.size_zero  = (pages == '0);
        o_stat.size_big   = (pages > pra_pkg::PAGES_W'(pra_pkg::NUM_PAGES));
        o_stat.mode_best  = (r_mode == pra_pkg::MODE_BEST_FIT);
        o_stat.found      = r_found;
        o_stat.scan_done  = scan_done;
        o_stat.last_pass  = r_pass;
        o_stat.mark_last  = (r_wcnt == r_want - CW'(1));
        o_stat.free_done  = (r_wcnt == r_want)
                          || (free_end >= (CW + 1)'(pra_pkg::NUM_PAGES));
        o_stat.out_free   = !r_out_vld || i_out_ready;
    end

    always_comb begin
        n_mode       = r_mode;
        n_req        = r_req;
        n_want       = r_want;
        n_nfp        = r_nfp;
        n_addr       = r_addr;
        n_rd_vld     = r_rd_vld;
        n_rd_addr    = r_rd_addr;
        n_run        = r_run;
        n_run_start  = r_run_start;
        n_found      = r_found;
        n_best_len   = r_best_len;
        n_best_start = r_best_start;
        n_pass       = r_pass;
        n_wcnt       = r_wcnt;
        n_status     = r_status;
        n_out_vld    = r_out_vld;
        n_out        = r_out;

        if (i_cfg_valid) begin
            n_mode = i_cfg_data;
        end
        if (i_cmd.capture) begin
            n_req = i_in_data;
        end
        if (i_cmd.clear) begin
            n_addr = r_addr + CW'(1);
        end

        if (i_cmd.scan_init) begin
            n_addr   = (r_mode == pra_pkg::MODE_BEST_FIT) ? '0 : r_nfp;
            n_rd_vld = 1'b0;
            n_run    = '0;
            n_found  = 1'b0;
            // a single pass covers the heap when it starts at page zero
            n_pass   = (r_mode == pra_pkg::MODE_BEST_FIT) || (r_nfp == '0);
            n_want   = CW'(pages);
            n_wcnt   = '0;
        end
        if (i_cmd.scan_restart) begin
            n_addr   = '0;
            n_rd_vld = 1'b0;
            n_run    = '0;
            n_pass   = 1'b1;
        end

        if (i_cmd.scan) begin
            // issue the next bitmap read
            if (r_addr != NPAGES) begin
                n_addr    = r_addr + CW'(1);
                n_rd_vld  = 1'b1;
                n_rd_addr = r_addr[AW-1:0];
            end else begin
                n_rd_vld = 1'b0;
            end
            // consume the page read last cycle
            if (r_rd_vld) begin
                if (r_mode == pra_pkg::MODE_BEST_FIT) begin
                    if (run_close && (close_len >= r_want)
                        && (!r_found || (close_len < r_best_len))) begin
                        n_found      = 1'b1;
                        n_best_len   = close_len;
                        n_best_start = close_start;
                    end
                end else if (!used && (run_inc == r_want)) begin
                    n_found      = 1'b1;
                    n_best_start = start_inc;
                end
                n_run       = used ? '0 : run_inc;
                n_run_start = used ? r_run_start : start_inc;
            end
        end

        if (i_cmd.len_load) begin
            n_want = len_rdata;
            n_wcnt = '0;
        end
        if (i_cmd.mark || i_cmd.free_clr) begin
            n_wcnt = r_wcnt + CW'(1);
        end
        if (i_cmd.commit) begin
            n_nfp = CW'(r_best_start) + r_want;
        end
        if (i_cmd.set_status) begin
            n_status = i_cmd.status;
        end

        if (i_cmd.load_out) begin
            n_out_vld = 1'b1;
            n_out.status = r_status;
            if (r_status == pra_pkg::ST_OK) begin
                n_out.page_index = o_stat.is_free ? r_req.free_page_index : r_best_start;
                n_out.page_count = r_want;
            end else begin
                n_out.page_index = '0;
                n_out.page_count = '0;
            end
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= pra_pkg::MODE_NEXT_FIT;
            r_nfp     <= '0;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_nfp     <= n_nfp;
            r_addr    <= n_addr;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_want       <= n_want;
        r_rd_addr    <= n_rd_addr;
        r_run        <= n_run;
        r_run_start  <= n_run_start;
        r_found      <= n_found;
        r_best_len   <= n_best_len;
        r_best_start <= n_best_start;
        r_pass       <= n_pass;
        r_wcnt       <= n_wcnt;
        r_status     <= n_status;
        r_out        <= n_out;
    end

    // Write port selection: clearing pass, marking a grant, releasing a block.
    always_comb begin
        bm_we = i_cmd.clear || i_cmd.mark || i_cmd.free_clr;
        if (i_cmd.clear) begin
            bm_waddr = r_addr[AW-1:0];
        end else if (i_cmd.mark) begin
            bm_waddr = r_best_start + r_wcnt[AW-1:0];
        end else begin
            bm_waddr = r_req.free_page_index + r_wcnt[AW-1:0];
        end
        bm_wdata = i_cmd.mark;

        len_we    = i_cmd.clear || i_cmd.commit;
        len_waddr = i_cmd.clear ? r_addr[AW-1:0] : r_best_start;
        len_wdata = i_cmd.clear ? '0 : r_want;
    end

    pra_ram #(
        .WIDTH (1),
        .DEPTH (pra_pkg::NUM_PAGES)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (bm_rdata)
    );

    pra_ram #(
        .WIDTH (CW),
        .DEPTH (pra_pkg::NUM_PAGES)
    ) u_runlen (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_raddr (r_req.free_page_index),
        .o_rdata (len_rdata)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/pra_ctrl.sv =====
// ---------------------------------------------------------------------------
// pra_ctrl
// Controller: sequences the clearing pass, request decode, bitmap scans,
// grant marking, block release and result hand-off.
// ---------------------------------------------------------------------------
module pra_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pra_pkg::t_stat i_stat,
    output pra_pkg::t_cmd  o_cmd
);

    pra_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pra_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;

        unique case (r_state)
            pra_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = pra_pkg::S_IDLE;
                end
            end
            pra_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = pra_pkg::S_DECODE;
                end
            end
            pra_pkg::S_DECODE: begin
                if (i_stat.is_free) begin
                    n_state = pra_pkg::S_FREE_LD;
                end else if (i_stat.size_zero) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = pra_pkg::ST_ZERO;
                    n_state          = pra_pkg::S_DONE;
                end else if (i_stat.size_big) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = pra_pkg::ST_NO_RUN;
                    n_state          = pra_pkg::S_DONE;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = pra_pkg::S_SCAN;
                end
            end
            pra_pkg::S_FREE_LD: begin
                o_cmd.len_load = 1'b1;
                n_state        = pra_pkg::S_FREE_CLR;
            end
            pra_pkg::S_FREE_CLR: begin
                if (i_stat.free_done) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = pra_pkg::ST_OK;
                    n_state          = pra_pkg::S_DONE;
                end else begin
                    o_cmd.free_clr = 1'b1;
                end
            end
            pra_pkg::S_SCAN: begin
                // next fit stops on the first hit, best fit only at the heap end
                if (i_stat.found && (!i_stat.mode_best || i_stat.scan_done)) begin
                    n_state = pra_pkg::S_MARK;
                end else if (i_stat.scan_done) begin
                    if (i_stat.last_pass) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = pra_pkg::ST_NO_RUN;
                        n_state          = pra_pkg::S_DONE;
                    end else begin
                        o_cmd.scan_restart = 1'b1;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            pra_pkg::S_MARK: begin
                o_cmd.mark = 1'b1;
                if (i_stat.mark_last) begin
                    o_cmd.commit     = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = pra_pkg::ST_OK;
                    n_state          = pra_pkg::S_DONE;
                end
            end
            pra_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = pra_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pra_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/page_run_allocator.sv =====
// Page run allocator over a heap of NUM_PAGES pages. After reset the block
// runs a clearing pass over its page bitmap and run length RAMs and takes
// no request until it ends (configuration writes are taken at any time).
// The bitmap RAM is read one page per cycle, and that read port sets the
// pace of a scan: a next-fit allocate scans from the pointer towards the
// heap end, stops on the first fitting run and, on a miss with a nonzero
// pointer, scans again from page zero; a best-fit allocate always scans the
// whole heap once. A grant then marks each granted page in the bitmap. A
// free reads the run length stored for the freed page and clears that many
// pages, up to the heap end; a zero or oversized request returns its status
// without a scan. The result register is loaded once it is free. Requests
// are handled one at a time; a finished result waits in its own register
// while the next request is taken.
// ---------------------------------------------------------------------------
// page_run_allocator
// Next-fit / best-fit page allocator with per-start run length bookkeeping.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module page_run_allocator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pra_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pra_pkg::t_out_rsp o_out_data
);

    pra_pkg::t_cmd  cmd;
    pra_pkg::t_stat stat;

    // placement mode is a plain register, always writable
    assign o_cfg_ready = 1'b1;

    pra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pra_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Pages are only marked used for a run the scan actually found.
    `PRA_ASSERT_IMPLY(a_mark_needs_run, i_clk, i_rst_n, cmd.mark, stat.found)
    // A new result only appears after the controller loads it.
    `PRA_ASSERT_IMPLY(a_out_from_load, i_clk, i_rst_n, $rose(o_out_valid), $past(cmd.load_out))
    // One request in flight: an accepted request closes the input.
    `PRA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule
